// File: hw/rtl/ffhp_pkg.sv
`default_nettype none

package ffhp_pkg;

    // Command codes carried by an input beat.
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_TRY   = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    // Status codes returned with every result beat.
    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_RELEASED = 2'd1,
        STAT_NOT_IN_USE  = 2'd2,
        STAT_EXHAUSTED   = 2'd3
    } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/fifo_free_list_handle_pool_top.sv
`default_nettype none

// Handle pool with a FIFO free list. A command beat is taken when start is high
// and busy is low; every command gives exactly one result beat, shown on
// handle_out/status for the single cycle in which done is high. The receiver
// cannot stall that beat, so it must sample it then. The cycle after
// acceptance (ST_EXEC) waits for the registered read of the
// in-use bitmap and of the released-handle queue, both synchronous memories,
// and the write-back happens at the end of that cycle. The result beat then
// appears together with busy going low, so a new command can be taken in the
// very cycle the previous result is shown, but not while one is in ST_EXEC.
// Allocate hands out the oldest released handle, else the next never-issued
// one, else reports the pool exhausted. Try-allocate uses released handles
// only. Deallocate of a handle that is not in use reports an error and
// changes nothing. No clearing pass is needed after reset: a bitmap entry at
// or above the count of fresh handles issued so far reads as free.
module fifo_free_list_handle_pool_top #(
    parameter int POOL_SIZE = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [7:0]            handle,
    output logic                  done,
    output logic [7:0]            handle_out,
    output ffhp_pkg::status_t     status
);

    import ffhp_pkg::*;

    localparam int IDX_W = (POOL_SIZE > 2) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int HW    = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(POOL_SIZE);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Control and pointer registers
    state_t             state_reg,  state_next;
    cmd_t               cmd_reg;
    logic [HW-1:0]      hreq_reg;
    logic [IDX_W-1:0]   head_reg,   head_next;
    logic [IDX_W-1:0]   tail_reg,   tail_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CNT_W-1:0]   fresh_reg,  fresh_next;
    logic               done_reg,   done_next;
    logic [7:0]         hout_reg,   hout_next;
    status_t            status_reg, status_next;

    // Memories and their registered read data
    logic               map_mem   [POOL_SIZE];
    logic [IDX_W-1:0]   queue_mem [POOL_SIZE];
    logic               map_rd_reg;
    logic [IDX_W-1:0]   queue_rd_reg;

    // Write-back controls
    logic               map_we;
    logic [IDX_W-1:0]   map_waddr;
    logic               map_wdata;
    logic               queue_we;

    logic               accept;
    logic [HW-1:0]      handle_wide;
    logic               in_use;
    logic [IDX_W-1:0]   grant;

    assign accept      = start && (state_reg == ST_IDLE);
    assign handle_wide = HW'(handle);
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign handle_out  = hout_reg;
    assign status      = status_reg;

    // Entries at or above the fresh count were never issued: treat them as free.
    assign in_use = (hreq_reg < HW'(fresh_reg)) && map_rd_reg;

    // Read both memories at acceptance; data is ready in ST_EXEC.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            map_rd_reg   <= map_mem[handle_wide[IDX_W-1:0]];
            queue_rd_reg <= queue_mem[head_reg];
        end
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (queue_we)
        begin
            queue_mem[tail_reg] <= hreq_reg[IDX_W-1:0];
        end
    end

    // Payload capture of the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            hreq_reg <= handle_wide;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        fresh_next  = fresh_reg;
        done_next   = 1'b0;
        hout_next   = hout_reg;
        status_next = status_reg;
        map_we      = 1'b0;
        map_waddr   = hreq_reg[IDX_W-1:0];
        map_wdata   = 1'b0;
        queue_we    = 1'b0;
        grant       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                status_next = STAT_OK;
                case (cmd_reg)
                    CMD_ALLOC, CMD_TRY:
                    begin
                        if (count_reg != '0)
                        begin
                            // Pop the oldest released handle.
                            grant      = queue_rd_reg;
                            head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            map_we     = 1'b1;
                            map_waddr  = queue_rd_reg;
                            map_wdata  = 1'b1;
                        end
                        else if (cmd_reg == CMD_TRY)
                        begin
                            status_next = STAT_NO_RELEASED;
                        end
                        else if (fresh_reg != POOL_FULL)
                        begin
                            // Issue a never-used handle.
                            grant      = fresh_reg[IDX_W-1:0];
                            fresh_next = fresh_reg + 1'b1;
                            map_we     = 1'b1;
                            map_waddr  = fresh_reg[IDX_W-1:0];
                            map_wdata  = 1'b1;
                        end
                        else
                        begin
                            status_next = STAT_EXHAUSTED;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (!in_use)
                        begin
                            status_next = STAT_NOT_IN_USE;
                        end
                        else
                        begin
                            // Clear the in-use bit and queue the handle.
                            map_we     = 1'b1;
                            map_waddr  = hreq_reg[IDX_W-1:0];
                            map_wdata  = 1'b0;
                            queue_we   = 1'b1;
                            tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
                hout_next  = HW'(grant) >> 0 == '0 ? 8'd0 : 8'(HW'(grant));
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            fresh_reg  <= '0;
            done_reg   <= 1'b0;
            hout_reg   <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            fresh_reg  <= fresh_next;
            done_reg   <= done_next;
            hout_reg   <= hout_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// File: sim/fifo_free_list_handle_pool_top_tb.sv
`timescale 1ns / 100ps

module fifo_free_list_handle_pool_top_tb;

    import ffhp_pkg::*;

    localparam int POOL        = 256;
    localparam int CYCLE_LIMIT = 100000;
    localparam int CHUNK       = 16;
    localparam int RANDOM_BEATS = 600;

    // The command encoding leaves one value unused; the pool must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Traffic mixes for the random part: fill the pool until it runs dry,
    // churn around the full point, then drain handles back.
    localparam int MIX_FILL  = 0;
    localparam int MIX_CHURN = 1;
    localparam int MIX_DRAIN = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] id;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0] id;
        status_t    code;
    } grant_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] command;
    logic [7:0] handle;
    logic       done;
    logic [7:0] handle_out;
    status_t    status;

    fifo_free_list_handle_pool_top #(
        .POOL_SIZE(POOL)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .handle    (handle),
        .done      (done),
        .handle_out(handle_out),
        .status    (status)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Command beats waiting to be driven, and grants the pool still owes.
    cmd_beat_t cmd_backlog[$];
    grant_t    grants_due[$];

    // Shadow copy of the pool: in-use bits, released FIFO, fresh counter.
    bit         model_in_use[POOL];
    logic [7:0] model_released[$];
    int         model_fresh;

    int        mismatches;
    int        taken_count;
    int        exhausted_seen;
    int        cycle_count;
    bit        beat_taken;
    cmd_beat_t next_beat;

    // Apply one command to the shadow pool and return the grant it yields.
    function automatic grant_t predict_grant(logic [1:0] op, logic [7:0] id);
        grant_t g;
        g.id   = 8'd0;
        g.code = STAT_OK;
        case (op)
            CMD_ALLOC, CMD_TRY:
            begin
                if (model_released.size() > 0)
                begin
                    // Oldest released handle goes out first.
                    g.id = model_released.pop_front();
                    model_in_use[g.id] = 1'b1;
                end
                else if (op == CMD_TRY)
                    g.code = STAT_NO_RELEASED;
                else if (model_fresh < POOL)
                begin
                    g.id = model_fresh[7:0];
                    model_in_use[g.id] = 1'b1;
                    model_fresh++;
                end
                else
                begin
                    g.code = STAT_EXHAUSTED;
                    exhausted_seen++;
                end
            end
            CMD_FREE:
            begin
                // Never issued or already released: reject, touch nothing.
                if (!model_in_use[id])
                    g.code = STAT_NOT_IN_USE;
                else
                begin
                    model_in_use[id] = 1'b0;
                    model_released.push_back(id);
                end
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    task automatic add_beat(logic [1:0] op, logic [7:0] id);
        cmd_beat_t b;
        b.op = op;
        b.id = id;
        cmd_backlog.push_back(b);
    endtask

    // Hold until every queued beat has been taken, so the shadow pool is current.
    task automatic settle_backlog();
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
    endtask

    // Queue one chunk of random traffic. Frees mostly target handles that are
    // in use right now, each picked at most once per chunk.
    task automatic add_random_chunk(int mix);
        logic [7:0] live[$];
        int         roll;
        int         k;
        int         alloc_cut;
        int         free_cut;
        int         try_cut;
        int         junk_cut;
        settle_backlog();
        for (int h = 0; h < POOL; h++)
            if (model_in_use[h])
                live.push_back(h[7:0]);
        case (mix)
            MIX_FILL:  begin alloc_cut = 85; free_cut = 93; try_cut = 96; junk_cut = 98; end
            MIX_CHURN: begin alloc_cut = 30; free_cut = 75; try_cut = 88; junk_cut = 95; end
            default:   begin alloc_cut = 8;  free_cut = 75; try_cut = 92; junk_cut = 97; end
        endcase
        for (int i = 0; i < CHUNK; i++)
        begin
            roll = $urandom_range(99);
            if (roll < alloc_cut)
                add_beat(CMD_ALLOC, 8'($urandom_range(255)));
            else if (roll < free_cut && live.size() > 0)
            begin
                k = $urandom_range(live.size() - 1);
                add_beat(CMD_FREE, live[k]);
                live.delete(k);
            end
            else if (roll < free_cut)
                add_beat(CMD_FREE, 8'($urandom_range(255)));
            else if (roll < try_cut)
                add_beat(CMD_TRY, 8'($urandom_range(255)));
            else if (roll < junk_cut)
                add_beat(CMD_FREE, 8'($urandom_range(255)));
            else
                add_beat(CMD_UNUSED, 8'($urandom_range(255)));
        end
    endtask

    task automatic note_mismatch(string what, grant_t want, logic [7:0] got_id,
                                 status_t got_code);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t MISMATCH %s: expected handle %0d status %0d, got handle %0d status %0d",
                     $time, what, want.id, want.code, got_id, got_code);
    endtask

    // Driver: change inputs on the falling edge. Keep start high until the beat
    // is taken; between beats idle about a third of the time, except for a
    // stretch of back-to-back beats in the middle of the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !beat_taken)
            begin
                // Beat still waiting on busy: hold it.
            end
            else if (cmd_backlog.size() > 0 &&
                     ((taken_count >= 250 && taken_count < 350) ||
                      $urandom_range(99) >= 34))
            begin
                next_beat = cmd_backlog.pop_front();
                command <= next_beat.op;
                handle  <= next_beat.id;
                start   <= 1'b1;
            end
            else
            begin
                // Idle: drop start and scramble the payload, which must be ignored.
                start   <= 1'b0;
                command <= 2'($urandom_range(3));
                handle  <= 8'($urandom_range(255));
            end
        end
    end

    // Monitor: sample on the rising edge. Check a result beat against the oldest
    // grant owed, then predict for a command beat taken at this same edge.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fifo_free_list_handle_pool_top regression: fail");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (grants_due.size() == 0)
                    note_mismatch("result beat with no command outstanding",
                                  '0, handle_out, status);
                else if (handle_out !== grants_due[0].id || status !== grants_due[0].code)
                    note_mismatch("result beat", grants_due.pop_front(), handle_out, status);
                else
                    void'(grants_due.pop_front());
            end
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                grants_due.push_back(predict_grant(command, handle));
                taken_count++;
            end
        end
        else
            beat_taken <= 1'b0;
    end

    initial
    begin
        int random_count;
        int mix;
        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_ALLOC;
        handle         = 8'd0;
        beat_taken     = 1'b0;
        mismatches     = 0;
        taken_count    = 0;
        exhausted_seen = 0;
        cycle_count    = 0;
        model_fresh    = 0;
        random_count   = 0;
        for (int h = 0; h < POOL; h++)
            model_in_use[h] = 1'b0;

        // Directed opening: empty try, frees of never-issued handles, fresh
        // issue, double free, FIFO order of reuse, the unused command, and
        // try draining the released queue back to empty.
        add_beat(CMD_TRY,    8'd0);
        add_beat(CMD_FREE,   8'd0);
        add_beat(CMD_FREE,   8'd255);
        add_beat(CMD_ALLOC,  8'd255);
        add_beat(CMD_ALLOC,  8'd0);
        add_beat(CMD_ALLOC,  8'd0);
        add_beat(CMD_FREE,   8'd1);
        add_beat(CMD_FREE,   8'd1);
        add_beat(CMD_FREE,   8'd0);
        add_beat(CMD_TRY,    8'd0);
        add_beat(CMD_ALLOC,  8'd0);
        add_beat(CMD_ALLOC,  8'd0);
        add_beat(CMD_UNUSED, 8'd255);
        add_beat(CMD_UNUSED, 8'd0);
        add_beat(CMD_FREE,   8'd2);
        add_beat(CMD_FREE,   8'd3);
        add_beat(CMD_TRY,    8'd255);
        add_beat(CMD_TRY,    8'd0);
        add_beat(CMD_TRY,    8'd0);
        add_beat(CMD_FREE,   8'hAA);
        add_beat(CMD_FREE,   8'h55);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random part: fill until the pool has reported exhaustion several
        // times, churn around the full point, then drain.
        while (random_count < RANDOM_BEATS)
        begin
            if (exhausted_seen < 6 && random_count < 420)
                mix = MIX_FILL;
            else if (random_count < 500)
                mix = MIX_CHURN;
            else
                mix = MIX_DRAIN;
            add_random_chunk(mix);
            random_count += CHUNK;
        end

        // Wait out the backlog and the owed grants, then keep the monitor running
        // after that to catch any stray result beat.
        settle_backlog();
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("fifo_free_list_handle_pool_top regression: pass");
        else
            $display("fifo_free_list_handle_pool_top regression: fail");
        $finish;
    end

endmodule
